// File: sv/stk_pkg.sv
package stk_pkg;

   // Result queue sizing.
   localparam int FIFO_DEPTH = 16;
   localparam int FIFO_AW = $clog2(FIFO_DEPTH);
   localparam int MAX_RESULTS = 4;
   // Input is held off while more entries than this wait in the queue.
   localparam int FIFO_ACCEPT_LIMIT = FIFO_DEPTH - 2 * MAX_RESULTS;

   // Token length limits.
   localparam logic [15:0] MAX_NUMBER_CHARS = 16'd1023;
   localparam logic [15:0] MAX_NAME_CHARS = 16'd255;

   // Token kinds.
   localparam logic [5:0] KIND_EOF         = 6'd0;
   localparam logic [5:0] KIND_RET_OK      = 6'd1;
   localparam logic [5:0] KIND_RET_ERR     = 6'd2;
   localparam logic [5:0] KIND_RET         = 6'd3;
   localparam logic [5:0] KIND_BREAK       = 6'd4;
   localparam logic [5:0] KIND_CONTINUE    = 6'd5;
   localparam logic [5:0] KIND_UNWRAP      = 6'd6;
   localparam logic [5:0] KIND_MATCH       = 6'd7;
   localparam logic [5:0] KIND_FAT_ARROW   = 6'd8;
   localparam logic [5:0] KIND_IMPORT_OP   = 6'd9;
   localparam logic [5:0] KIND_OPEN_ARENA  = 6'd10;
   localparam logic [5:0] KIND_CLOSE_ARENA = 6'd11;
   localparam logic [5:0] KIND_OPEN_TABLE  = 6'd12;
   localparam logic [5:0] KIND_CLOSE_TABLE = 6'd13;
   localparam logic [5:0] KIND_ARROW       = 6'd14;
   localparam logic [5:0] KIND_BIN         = 6'd15;
   localparam logic [5:0] KIND_UNARY       = 6'd16;
   localparam logic [5:0] KIND_LPAREN      = 6'd17;
   localparam logic [5:0] KIND_RPAREN      = 6'd18;
   localparam logic [5:0] KIND_LBRACE      = 6'd19;
   localparam logic [5:0] KIND_RBRACE      = 6'd20;
   localparam logic [5:0] KIND_LBRACKET    = 6'd21;
   localparam logic [5:0] KIND_RBRACKET    = 6'd22;
   localparam logic [5:0] KIND_SEMI        = 6'd23;
   localparam logic [5:0] KIND_COMMA       = 6'd24;
   localparam logic [5:0] KIND_DOT         = 6'd25;
   localparam logic [5:0] KIND_EQUALS      = 6'd26;
   localparam logic [5:0] KIND_QUESTION    = 6'd27;
   localparam logic [5:0] KIND_COLON       = 6'd28;
   localparam logic [5:0] KIND_HASH        = 6'd29;
   localparam logic [5:0] KIND_AT          = 6'd30;
   localparam logic [5:0] KIND_DOLLAR      = 6'd31;
   localparam logic [5:0] KIND_NUMBER      = 6'd32;
   localparam logic [5:0] KIND_IDENT       = 6'd33;
   localparam logic [5:0] KIND_LET         = 6'd34;
   localparam logic [5:0] KIND_BOOL        = 6'd35;
   localparam logic [5:0] KIND_NIL         = 6'd36;
   localparam logic [5:0] KIND_AS          = 6'd37;
   localparam logic [5:0] KIND_IMPORT_NAME = 6'd38;
   localparam logic [5:0] KIND_STRING      = 6'd39;
   localparam logic [5:0] KIND_NONE        = 6'd63;

   // Lexer modes.
   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_NUMBER  = 3'd1;
   localparam logic [2:0] MODE_NAME    = 3'd2;
   localparam logic [2:0] MODE_STRING  = 3'd3;
   localparam logic [2:0] MODE_COMMENT = 3'd4;
   localparam logic [2:0] MODE_HALTED  = 3'd5;

   // Error codes.
   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_POINT  = 3'd1;
   localparam logic [2:0] ERR_UNTERM = 3'd2;
   localparam logic [2:0] ERR_BYTE   = 3'd3;
   localparam logic [2:0] ERR_LONG   = 3'd4;

   // Keyword tracker codes.
   localparam logic [2:0] KW_NONE  = 3'd0;
   localparam logic [2:0] KW_LET   = 3'd1;
   localparam logic [2:0] KW_TRUE  = 3'd2;
   localparam logic [2:0] KW_FALSE = 3'd3;
   localparam logic [2:0] KW_NIL   = 3'd4;
   localparam logic [2:0] KW_AS    = 3'd5;

   typedef struct packed {
      logic [5:0]  token_kind;
      logic [31:0] start_line;
      logic [15:0] start_column;
      logic [31:0] start_offset;
      logic [15:0] token_length;
      logic [2:0]  error_code;
      logic        last_token;
   } result_type;

   // Results of one item handed from the lexer to the result queue.
   typedef struct packed {
      logic [2:0]                        count;
      result_type [MAX_RESULTS-1:0]      items;
   } push_type;

   function automatic result_type make_result(logic [5:0] kind, logic [31:0] line,
                                              logic [15:0] col, logic [31:0] off,
                                              logic [15:0] len, logic [2:0] err,
                                              logic last);
      result_type r;
      r.token_kind   = kind;
      r.start_line   = line;
      r.start_column = col;
      r.start_offset = off;
      r.token_length = len;
      r.error_code   = err;
      r.last_token   = last;
      return r;
   endfunction

   // Keyword a name may become, from its first character.
   function automatic logic [2:0] kw_start(logic [7:0] ch);
      logic [2:0] k;
      case (ch)
         "l":     k = KW_LET;
         "t":     k = KW_TRUE;
         "f":     k = KW_FALSE;
         "n":     k = KW_NIL;
         "a":     k = KW_AS;
         default: k = KW_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [15:0] kw_len(logic [2:0] k);
      logic [15:0] n;
      case (k)
         KW_LET:   n = 16'd3;
         KW_TRUE:  n = 16'd4;
         KW_FALSE: n = 16'd5;
         KW_NIL:   n = 16'd3;
         KW_AS:    n = 16'd2;
         default:  n = 16'd0;
      endcase
      return n;
   endfunction

   function automatic logic [5:0] kw_kind(logic [2:0] k);
      logic [5:0] kind;
      case (k)
         KW_LET:   kind = KIND_LET;
         KW_TRUE:  kind = KIND_BOOL;
         KW_FALSE: kind = KIND_BOOL;
         KW_NIL:   kind = KIND_NIL;
         KW_AS:    kind = KIND_AS;
         default:  kind = KIND_IDENT;
      endcase
      return kind;
   endfunction

   // Character of a keyword at a position inside it.
   function automatic logic [7:0] kw_char(logic [2:0] k, logic [2:0] idx);
      logic [7:0] c;
      c = 8'd0;
      case (k)
         KW_LET: begin
            case (idx)
               3'd0:    c = "l";
               3'd1:    c = "e";
               3'd2:    c = "t";
               default: c = 8'd0;
            endcase
         end
         KW_TRUE: begin
            case (idx)
               3'd0:    c = "t";
               3'd1:    c = "r";
               3'd2:    c = "u";
               3'd3:    c = "e";
               default: c = 8'd0;
            endcase
         end
         KW_FALSE: begin
            case (idx)
               3'd0:    c = "f";
               3'd1:    c = "a";
               3'd2:    c = "l";
               3'd3:    c = "s";
               3'd4:    c = "e";
               default: c = 8'd0;
            endcase
         end
         KW_NIL: begin
            case (idx)
               3'd0:    c = "n";
               3'd1:    c = "i";
               3'd2:    c = "l";
               default: c = 8'd0;
            endcase
         end
         KW_AS: begin
            case (idx)
               3'd0:    c = "a";
               3'd1:    c = "s";
               default: c = 8'd0;
            endcase
         end
         default: c = 8'd0;
      endcase
      return c;
   endfunction

endpackage

// File: sv/stk_core.sv
module stk_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_accept,
   input  logic [7:0]        in_byte,
   input  logic              in_end,
   output stk_pkg::push_type push
);

   // Passes of the step logic needed to settle one item. Bytes are only held
   // back in idle mode, and the worst case is a held "_>" followed by a byte
   // that ends it: the underscore starts a name, the '>' ends that name, the
   // '>' is lexed alone, and then the new byte is lexed.
   localparam int LEX_PASSES = 4;

   typedef struct packed {
      logic [2:0]       mode;
      logic [3:0][7:0]  la;
      logic [2:0]       cnt;
      logic [31:0]      line;
      logic [15:0]      col;
      logic [31:0]      off;
      logic [31:0]      tsl;
      logic [15:0]      tsc;
      logic [31:0]      tso;
      logic [15:0]      chars;
      logic             point;
      logic             esc;
      logic [2:0]       kwt;
      logic             dot;
      logic [7:0]       quote;
      logic [5:0]       prev;
   } lex_state_type;

   function automatic lex_state_type state_reset();
      lex_state_type r;
      r       = '0;
      r.mode  = stk_pkg::MODE_IDLE;
      r.line  = 32'd1;
      r.col   = 16'd1;
      r.kwt   = stk_pkg::KW_NONE;
      r.prev  = stk_pkg::KIND_NONE;
      return r;
   endfunction

   function automatic logic [5:0] name_kind(logic [2:0] kwt, logic [15:0] chars,
                                            logic dot);
      logic [2:0] k;
      k = (kwt <= stk_pkg::KW_AS) ? kwt : stk_pkg::KW_NONE;
      if (k != stk_pkg::KW_NONE && chars == stk_pkg::kw_len(k)) begin
         return stk_pkg::kw_kind(k);
      end else if (dot) begin
         return stk_pkg::KIND_IMPORT_NAME;
      end
      return stk_pkg::KIND_IDENT;
   endfunction

   logic          in_v_ff, in_v_in;
   logic [7:0]    in_byte_ff;
   logic          in_end_ff;
   lex_state_type st_ff, st_in;
   stk_pkg::result_type [stk_pkg::MAX_RESULTS-1:0] res;
   logic [2:0]    res_n;

   // Input register: one item is lexed in the cycle after it is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= in_v_in;
      end
      in_byte_ff <= in_byte;
      in_end_ff  <= in_end;
   end

   assign in_v_in = in_accept;

   // Lexer state advances once per lexed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= state_reset();
      end else if (in_v_ff) begin
         st_ff <= st_in;
      end
   end

   // One pass over the item: append the byte, then run the step logic until
   // the queue is empty or a punctuator needs more bytes.
   always_comb begin
      lex_state_type       s;
      stk_pkg::result_type e_item;
      logic                e_en;
      logic                stop, at_end, fall, do_punct, nl;
      logic                k1, k2, k3, u1, u2, u3;
      logic [7:0]          b0, b1, b2, b3;
      logic [5:0]          p_kind, single_kind;
      logic [2:0]          p_len, tk;
      logic                is_digit, is_letter, is_name;

      s      = st_ff;
      res    = '0;
      res_n  = 3'd0;
      at_end = in_end_ff;
      stop   = 1'b0;
      e_item = '0;
      e_en   = 1'b0;
      fall   = 1'b0;
      do_punct = 1'b0;
      nl     = 1'b0;
      k1 = 1'b0; k2 = 1'b0; k3 = 1'b0; u1 = 1'b0; u2 = 1'b0; u3 = 1'b0;
      b0 = 8'd0; b1 = 8'd0; b2 = 8'd0; b3 = 8'd0;
      p_kind = stk_pkg::KIND_EOF;
      single_kind = stk_pkg::KIND_BIN;
      p_len = 3'd0;
      tk = 3'd0;
      is_digit = 1'b0; is_letter = 1'b0; is_name = 1'b0;

      if (s.mode == stk_pkg::MODE_HALTED) begin
         // Halted after an error: ignore bytes up to the end of the source.
         if (at_end) begin
            s = state_reset();
         end
      end else begin
         s.la[s.cnt[1:0]] = in_byte_ff;
         s.cnt = s.cnt + 3'd1;

         for (int it = 0; it < LEX_PASSES; it++) begin
            if (!stop && s.cnt != 3'd0 && s.mode != stk_pkg::MODE_HALTED) begin
               e_en     = 1'b0;
               e_item   = '0;
               fall     = 1'b0;
               do_punct = 1'b0;
               p_kind   = stk_pkg::KIND_EOF;
               p_len    = 3'd0;
               tk       = 3'd0;
               nl       = 1'b0;
               b0 = s.la[0];
               b1 = s.la[1];
               b2 = s.la[2];
               b3 = s.la[3];
               k1 = s.cnt > 3'd1;
               k2 = s.cnt > 3'd2;
               k3 = s.cnt > 3'd3;
               u1 = !k1 && !at_end;
               u2 = !k2 && !at_end;
               u3 = !k3 && !at_end;
               is_digit  = (b0 >= "0") && (b0 <= "9");
               is_letter = ((b0 >= "a") && (b0 <= "z")) || ((b0 >= "A") && (b0 <= "Z")) ||
                           b0[7];
               is_name   = is_letter || is_digit || b0 == "_" || b0 == ".";
               single_kind = (s.prev == stk_pkg::KIND_NONE || s.prev == stk_pkg::KIND_BIN ||
                              s.prev == stk_pkg::KIND_LPAREN || s.prev == stk_pkg::KIND_COMMA ||
                              s.prev == stk_pkg::KIND_EQUALS) ?
                             stk_pkg::KIND_UNARY : stk_pkg::KIND_BIN;

               unique case (s.mode)
                  stk_pkg::MODE_IDLE: begin
                     // Whitespace, punctuators and the start of longer tokens.
                     case (b0) inside
                        " ", "\t", "\r": tk = 3'd1;
                        "\n": nl = 1'b1;
                        "_": begin
                           if (u1) begin
                              stop = 1'b1;
                           end else if (k1 && b1 == ">") begin
                              if (u2) begin
                                 stop = 1'b1;
                              end else if (k2 && b2 == ">") begin
                                 if (u3) begin
                                    stop = 1'b1;
                                 end else begin
                                    do_punct = 1'b1;
                                    if (k3 && b3 == "@") begin
                                       p_kind = stk_pkg::KIND_RET_OK;  p_len = 3'd4;
                                    end else if (k3 && b3 == "!") begin
                                       p_kind = stk_pkg::KIND_RET_ERR; p_len = 3'd4;
                                    end else begin
                                       p_kind = stk_pkg::KIND_RET;     p_len = 3'd3;
                                    end
                                 end
                              end else begin
                                 fall = 1'b1;
                              end
                           end else if (k1 && b1 == "_") begin
                              if (u2) begin
                                 stop = 1'b1;
                              end else if (k2 && b2 == ">") begin
                                 do_punct = 1'b1;
                                 p_kind = stk_pkg::KIND_CONTINUE; p_len = 3'd3;
                              end else begin
                                 fall = 1'b1;
                              end
                           end else begin
                              fall = 1'b1;
                           end
                        end
                        "~": begin
                           if (u1) begin
                              stop = 1'b1;
                           end else if (k1 && b1 == "!") begin
                              if (u2) begin
                                 stop = 1'b1;
                              end else if (k2 && b2 == "!") begin
                                 do_punct = 1'b1;
                                 p_kind = stk_pkg::KIND_BREAK; p_len = 3'd3;
                              end else begin
                                 fall = 1'b1;
                              end
                           end else if (k1 && b1 == ">") begin
                              do_punct = 1'b1;
                              p_kind = stk_pkg::KIND_IMPORT_OP; p_len = 3'd2;
                           end else begin
                              fall = 1'b1;
                           end
                        end
                        "!": begin
                           if (u1) begin
                              stop = 1'b1;
                           end else begin
                              do_punct = 1'b1;
                              if (k1 && b1 == "?") begin
                                 p_kind = stk_pkg::KIND_UNWRAP; p_len = 3'd2;
                              end else if (k1 && b1 == "=") begin
                                 p_kind = stk_pkg::KIND_BIN; p_len = 3'd2;
                              end else begin
                                 p_kind = single_kind; p_len = 3'd1;
                              end
                           end
                        end
                        "?": begin
                           if (u1) begin
                              stop = 1'b1;
                           end else begin
                              do_punct = 1'b1;
                              if (k1 && b1 == "?") begin
                                 p_kind = stk_pkg::KIND_MATCH; p_len = 3'd2;
                              end else begin
                                 p_kind = stk_pkg::KIND_QUESTION; p_len = 3'd1;
                              end
                           end
                        end
                        "=": begin
                           if (u1) begin
                              stop = 1'b1;
                           end else begin
                              do_punct = 1'b1;
                              if (k1 && b1 == ">") begin
                                 p_kind = stk_pkg::KIND_FAT_ARROW; p_len = 3'd2;
                              end else if (k1 && b1 == "=") begin
                                 p_kind = stk_pkg::KIND_BIN; p_len = 3'd2;
                              end else begin
                                 p_kind = stk_pkg::KIND_EQUALS; p_len = 3'd1;
                              end
                           end
                        end
                        "|": begin
                           if (u1) begin
                              stop = 1'b1;
                           end else begin
                              do_punct = 1'b1;
                              if (k1 && b1 == "{") begin
                                 p_kind = stk_pkg::KIND_OPEN_ARENA; p_len = 3'd2;
                              end else if (k1 && b1 == ">") begin
                                 p_kind = stk_pkg::KIND_OPEN_TABLE; p_len = 3'd2;
                              end else if (k1 && b1 == "|") begin
                                 p_kind = stk_pkg::KIND_BIN; p_len = 3'd2;
                              end else begin
                                 p_kind = stk_pkg::KIND_BIN; p_len = 3'd1;
                              end
                           end
                        end
                        "}": begin
                           if (u1) begin
                              stop = 1'b1;
                           end else begin
                              do_punct = 1'b1;
                              if (k1 && b1 == "|") begin
                                 p_kind = stk_pkg::KIND_CLOSE_ARENA; p_len = 3'd2;
                              end else begin
                                 p_kind = stk_pkg::KIND_RBRACE; p_len = 3'd1;
                              end
                           end
                        end
                        "<": begin
                           if (u1) begin
                              stop = 1'b1;
                           end else begin
                              do_punct = 1'b1;
                              if (k1 && b1 == "|") begin
                                 p_kind = stk_pkg::KIND_CLOSE_TABLE; p_len = 3'd2;
                              end else if (k1 && (b1 == "=" || b1 == "<")) begin
                                 p_kind = stk_pkg::KIND_BIN; p_len = 3'd2;
                              end else begin
                                 p_kind = single_kind; p_len = 3'd1;
                              end
                           end
                        end
                        "-": begin
                           if (u1) begin
                              stop = 1'b1;
                           end else if (k1 && b1 == "#") begin
                              s.mode = stk_pkg::MODE_COMMENT;
                              tk = 3'd1;
                           end else begin
                              do_punct = 1'b1;
                              if (k1 && b1 == ">") begin
                                 p_kind = stk_pkg::KIND_ARROW; p_len = 3'd2;
                              end else begin
                                 p_kind = single_kind; p_len = 3'd1;
                              end
                           end
                        end
                        ">": begin
                           if (u1) begin
                              stop = 1'b1;
                           end else begin
                              do_punct = 1'b1;
                              if (k1 && (b1 == "=" || b1 == ">")) begin
                                 p_kind = stk_pkg::KIND_BIN; p_len = 3'd2;
                              end else begin
                                 p_kind = single_kind; p_len = 3'd1;
                              end
                           end
                        end
                        "*": begin
                           if (u1) begin
                              stop = 1'b1;
                           end else begin
                              do_punct = 1'b1;
                              if (k1 && b1 == "*") begin
                                 p_kind = stk_pkg::KIND_BIN; p_len = 3'd2;
                              end else begin
                                 p_kind = single_kind; p_len = 3'd1;
                              end
                           end
                        end
                        "&": begin
                           // Combined ampersand operators are always binary.
                           p_kind = stk_pkg::KIND_BIN;
                           if (u1) begin
                              stop = 1'b1;
                           end else if (k1 && (b1 == "&" || b1 == "+" || b1 == "-" ||
                                               b1 == "/" || b1 == "%" || b1 == "e" ||
                                               b1 == "|" || b1 == "~")) begin
                              do_punct = 1'b1; p_len = 3'd2;
                           end else if (k1 && b1 == "*") begin
                              if (u2) begin
                                 stop = 1'b1;
                              end else begin
                                 do_punct = 1'b1;
                                 p_len = (k2 && b2 == "*") ? 3'd3 : 3'd2;
                              end
                           end else if (k1 && (b1 == "<" || b1 == ">")) begin
                              if (u2) begin
                                 stop = 1'b1;
                              end else begin
                                 do_punct = 1'b1;
                                 p_len = (k2 && b2 == b1) ? 3'd3 : 3'd1;
                              end
                           end else begin
                              do_punct = 1'b1; p_len = 3'd1;
                           end
                        end
                        "+", "/", "%", "^": begin
                           do_punct = 1'b1; p_kind = single_kind; p_len = 3'd1;
                        end
                        "(": begin do_punct = 1'b1; p_kind = stk_pkg::KIND_LPAREN;   p_len = 3'd1; end
                        ")": begin do_punct = 1'b1; p_kind = stk_pkg::KIND_RPAREN;   p_len = 3'd1; end
                        "{": begin do_punct = 1'b1; p_kind = stk_pkg::KIND_LBRACE;   p_len = 3'd1; end
                        "[": begin do_punct = 1'b1; p_kind = stk_pkg::KIND_LBRACKET; p_len = 3'd1; end
                        "]": begin do_punct = 1'b1; p_kind = stk_pkg::KIND_RBRACKET; p_len = 3'd1; end
                        ";": begin do_punct = 1'b1; p_kind = stk_pkg::KIND_SEMI;     p_len = 3'd1; end
                        ",": begin do_punct = 1'b1; p_kind = stk_pkg::KIND_COMMA;    p_len = 3'd1; end
                        ".": begin do_punct = 1'b1; p_kind = stk_pkg::KIND_DOT;      p_len = 3'd1; end
                        ":": begin do_punct = 1'b1; p_kind = stk_pkg::KIND_COLON;    p_len = 3'd1; end
                        "#": begin do_punct = 1'b1; p_kind = stk_pkg::KIND_HASH;     p_len = 3'd1; end
                        "@": begin do_punct = 1'b1; p_kind = stk_pkg::KIND_AT;       p_len = 3'd1; end
                        "$": begin do_punct = 1'b1; p_kind = stk_pkg::KIND_DOLLAR;   p_len = 3'd1; end
                        "\"", "'": begin
                           s.tsl   = s.line;
                           s.tsc   = s.col;
                           s.tso   = s.off;
                           s.quote = b0;
                           s.esc   = 1'b0;
                           s.chars = 16'd0;
                           s.mode  = stk_pkg::MODE_STRING;
                           tk      = 3'd1;
                        end
                        default: fall = 1'b1;
                     endcase

                     // Numbers, names, or a byte that starts nothing.
                     if (fall) begin
                        if (is_digit) begin
                           s.tsl   = s.line;
                           s.tsc   = s.col;
                           s.tso   = s.off;
                           s.chars = 16'd1;
                           s.point = 1'b0;
                           s.mode  = stk_pkg::MODE_NUMBER;
                           tk      = 3'd1;
                        end else if (is_letter || b0 == "_") begin
                           s.tsl   = s.line;
                           s.tsc   = s.col;
                           s.tso   = s.off;
                           s.chars = 16'd1;
                           s.dot   = 1'b0;
                           s.kwt   = stk_pkg::kw_start(b0);
                           s.mode  = stk_pkg::MODE_NAME;
                           tk      = 3'd1;
                        end else begin
                           e_en   = 1'b1;
                           e_item = stk_pkg::make_result(stk_pkg::KIND_EOF, s.line, s.col,
                                                         s.off, 16'd1, stk_pkg::ERR_BYTE, 1'b1);
                           s.mode = stk_pkg::MODE_HALTED;
                           s.cnt  = 3'd0;
                        end
                     end

                     if (do_punct) begin
                        s.tsl  = s.line;
                        s.tsc  = s.col;
                        s.tso  = s.off;
                        e_en   = 1'b1;
                        e_item = stk_pkg::make_result(p_kind, s.line, s.col, s.off,
                                                      {13'd0, p_len}, stk_pkg::ERR_NONE, 1'b0);
                        s.prev = p_kind;
                        tk     = p_len;
                     end
                  end

                  stk_pkg::MODE_NUMBER: begin
                     if (is_digit || b0 == ".") begin
                        if (b0 == "." && s.point) begin
                           e_en   = 1'b1;
                           e_item = stk_pkg::make_result(stk_pkg::KIND_EOF, s.tsl, s.tsc, s.tso,
                                                         s.chars, stk_pkg::ERR_POINT, 1'b1);
                           s.mode = stk_pkg::MODE_HALTED;
                           s.cnt  = 3'd0;
                        end else if (s.chars >= stk_pkg::MAX_NUMBER_CHARS) begin
                           e_en   = 1'b1;
                           e_item = stk_pkg::make_result(stk_pkg::KIND_EOF, s.tsl, s.tsc, s.tso,
                                                         s.chars, stk_pkg::ERR_LONG, 1'b1);
                           s.mode = stk_pkg::MODE_HALTED;
                           s.cnt  = 3'd0;
                        end else begin
                           s.point = s.point | (b0 == ".");
                           s.chars = s.chars + 16'd1;
                           tk      = 3'd1;
                        end
                     end else begin
                        e_en   = 1'b1;
                        e_item = stk_pkg::make_result(stk_pkg::KIND_NUMBER, s.tsl, s.tsc, s.tso,
                                                      s.chars, stk_pkg::ERR_NONE, 1'b0);
                        s.prev = stk_pkg::KIND_NUMBER;
                        s.mode = stk_pkg::MODE_IDLE;
                     end
                  end

                  stk_pkg::MODE_NAME: begin
                     if (!is_name) begin
                        e_en   = 1'b1;
                        e_item = stk_pkg::make_result(name_kind(s.kwt, s.chars, s.dot),
                                                      s.tsl, s.tsc, s.tso, s.chars,
                                                      stk_pkg::ERR_NONE, 1'b0);
                        s.prev = name_kind(s.kwt, s.chars, s.dot);
                        s.mode = stk_pkg::MODE_IDLE;
                     end else if (s.chars >= stk_pkg::MAX_NAME_CHARS) begin
                        e_en   = 1'b1;
                        e_item = stk_pkg::make_result(stk_pkg::KIND_EOF, s.tsl, s.tsc, s.tso,
                                                      s.chars, stk_pkg::ERR_LONG, 1'b1);
                        s.mode = stk_pkg::MODE_HALTED;
                        s.cnt  = 3'd0;
                     end else begin
                        s.dot = s.dot | (b0 == ".");
                        // Keep the keyword candidate only while the text matches it.
                        if (s.kwt != stk_pkg::KW_NONE && s.kwt <= stk_pkg::KW_AS) begin
                           if (!(s.chars < stk_pkg::kw_len(s.kwt) &&
                                 stk_pkg::kw_char(s.kwt, s.chars[2:0]) == b0)) begin
                              s.kwt = stk_pkg::KW_NONE;
                           end
                        end else begin
                           s.kwt = stk_pkg::KW_NONE;
                        end
                        s.chars = s.chars + 16'd1;
                        tk      = 3'd1;
                     end
                  end

                  stk_pkg::MODE_STRING: begin
                     if (b0 == s.quote && !s.esc) begin
                        // A string reports the line of its closing quote.
                        e_en   = 1'b1;
                        e_item = stk_pkg::make_result(stk_pkg::KIND_STRING, s.line, s.tsc,
                                                      s.tso, s.chars, stk_pkg::ERR_NONE, 1'b0);
                        s.prev = stk_pkg::KIND_STRING;
                        s.mode = stk_pkg::MODE_IDLE;
                        tk     = 3'd1;
                     end else begin
                        s.esc = (b0 == "\\") && !s.esc;
                        if (s.chars != 16'hFFFF) begin
                           s.chars = s.chars + 16'd1;
                        end
                        if (b0 == "\n") begin
                           nl = 1'b1;
                        end else begin
                           tk = 3'd1;
                        end
                     end
                  end

                  stk_pkg::MODE_COMMENT: begin
                     // The line feed that ends a comment is lexed in idle mode.
                     if (b0 == "\n") begin
                        s.mode = stk_pkg::MODE_IDLE;
                     end else begin
                        tk = 3'd1;
                     end
                  end

                  default: stop = 1'b1;
               endcase

               if (e_en && res_n < 3'd4) begin
                  res[res_n[1:0]] = e_item;
                  res_n = res_n + 3'd1;
               end

               // Consume bytes from the queue and advance the position.
               if (nl) begin
                  s.la   = s.la >> 8;
                  s.cnt  = s.cnt - 3'd1;
                  s.line = s.line + 32'd1;
                  s.col  = 16'd1;
                  s.off  = s.off + 32'd1;
               end else if (tk != 3'd0) begin
                  s.la  = s.la >> {tk, 3'b000};
                  s.cnt = s.cnt - tk;
                  s.col = s.col + {13'd0, tk};
                  s.off = s.off + {29'd0, tk};
               end
            end
         end

         // End of source: close a number or name, fail a string; EOF unless halted.
         if (at_end) begin
            e_en   = 1'b0;
            e_item = '0;
            case (s.mode)
               stk_pkg::MODE_NUMBER: begin
                  e_en   = 1'b1;
                  e_item = stk_pkg::make_result(stk_pkg::KIND_NUMBER, s.tsl, s.tsc, s.tso,
                                                s.chars, stk_pkg::ERR_NONE, 1'b0);
               end
               stk_pkg::MODE_NAME: begin
                  e_en   = 1'b1;
                  e_item = stk_pkg::make_result(name_kind(s.kwt, s.chars, s.dot), s.tsl,
                                                s.tsc, s.tso, s.chars, stk_pkg::ERR_NONE, 1'b0);
               end
               stk_pkg::MODE_STRING: begin
                  e_en   = 1'b1;
                  e_item = stk_pkg::make_result(stk_pkg::KIND_EOF, s.tsl, s.tsc, s.tso,
                                                s.chars, stk_pkg::ERR_UNTERM, 1'b1);
                  s.mode = stk_pkg::MODE_HALTED;
               end
               default: e_en = 1'b0;
            endcase
            if (e_en && res_n < 3'd4) begin
               res[res_n[1:0]] = e_item;
               res_n = res_n + 3'd1;
            end
            if (s.mode != stk_pkg::MODE_HALTED && res_n < 3'd4) begin
               res[res_n[1:0]] = stk_pkg::make_result(stk_pkg::KIND_EOF, s.line, s.col, s.off,
                                                      16'd0, stk_pkg::ERR_NONE, 1'b1);
               res_n = res_n + 3'd1;
            end
            s = state_reset();
         end
      end

      st_in = s;
   end

   assign push.count = in_v_ff ? res_n : 3'd0;
   assign push.items = res;

endmodule

// File: sv/stk_fifo.sv
module stk_fifo (
   input  logic                clock,
   input  logic                reset,
   input  stk_pkg::push_type   push,
   output logic                almost_full,
   output logic                out_valid,
   input  logic                out_stall,
   output stk_pkg::result_type out_item
);

   stk_pkg::result_type              mem_ff [stk_pkg::FIFO_DEPTH];
   logic [stk_pkg::FIFO_AW-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [stk_pkg::FIFO_AW:0]        count_ff, count_in;
   logic                             pop;

   // Results of one item are written at consecutive slots.
   always_ff @(posedge clock) begin
      for (int i = 0; i < stk_pkg::MAX_RESULTS; i++) begin
         if (3'(i) < push.count) begin
            mem_ff[wr_ff + stk_pkg::FIFO_AW'(i)] <= push.items[i];
         end
      end
   end

   assign pop      = out_valid && !out_stall;
   assign wr_in    = wr_ff + stk_pkg::FIFO_AW'(push.count);
   assign rd_in    = rd_ff + stk_pkg::FIFO_AW'(pop);
   assign count_in = count_ff + (stk_pkg::FIFO_AW + 1)'(push.count)
                     - (stk_pkg::FIFO_AW + 1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Room for the item in the lexer and one more is kept free.
   assign almost_full = count_ff > (stk_pkg::FIFO_AW + 1)'(stk_pkg::FIFO_ACCEPT_LIMIT);
   assign out_valid   = count_ff != '0;
   assign out_item    = mem_ff[rd_ff];

endmodule

// File: sv/source_tokenizer.sv
// An accepted byte passes the lexer input register; its results then enter the result queue.
// Throughput: one source byte per cycle while req_stall is low; each byte is lexed combinationally.
// Results wait in a 16-entry queue; req_stall rises while more than 8 are waiting.
// Reset is synchronous and active high: line 1, column 1, offset 0, queue empty.
// The same lexer reset follows every byte that carries end_of_source.
module source_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_source_byte,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_token_kind,
   output logic [31:0] rsp_start_line,
   output logic [15:0] rsp_start_column,
   output logic [31:0] rsp_start_offset,
   output logic [15:0] rsp_token_length,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last_token
);

   stk_pkg::push_type   push;
   stk_pkg::result_type out_item;
   logic                almost_full;

   assign req_stall = almost_full;

   // Lexer: input register and combinational step logic.
   stk_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_valid && !req_stall),
      .in_byte   (req_source_byte),
      .in_end    (req_end_of_source),
      .push      (push)
   );

   // Result queue toward the rsp channel.
   stk_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .almost_full (almost_full),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_item    (out_item)
   );

   assign rsp_token_kind   = out_item.token_kind;
   assign rsp_start_line   = out_item.start_line;
   assign rsp_start_column = out_item.start_column;
   assign rsp_start_offset = out_item.start_offset;
   assign rsp_token_length = out_item.token_length;
   assign rsp_error_code   = out_item.error_code;
   assign rsp_last_token   = out_item.last_token;

endmodule

// File: sv/stk_checker.sv
module stk_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_source_byte,
   input logic        req_end_of_source,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [5:0]  rsp_token_kind,
   input logic [31:0] rsp_start_line,
   input logic [15:0] rsp_start_column,
   input logic [31:0] rsp_start_offset,
   input logic [15:0] rsp_token_length,
   input logic [2:0]  rsp_error_code,
   input logic        rsp_last_token
);

   // After reset nothing waits and the input side is open.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result queue not empty or input stalled after reset");

   // A stalled input item holds its payload.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_source_byte) &&
      $stable(req_end_of_source))
      else $error("stalled input item changed");

   // A stalled item holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_kind) &&
      $stable(rsp_start_line) && $stable(rsp_start_column) &&
      $stable(rsp_start_offset) && $stable(rsp_token_length) && $stable(rsp_error_code) &&
      $stable(rsp_last_token))
      else $error("stalled result item changed");

   // Every error ends its source and carries the EOF kind.
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != stk_pkg::ERR_NONE |->
      rsp_last_token && rsp_token_kind == stk_pkg::KIND_EOF)
      else $error("error item without end marker");

   // The EOF token that ends a source has no text.
   a_eof_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_token && rsp_error_code == stk_pkg::ERR_NONE |->
      rsp_token_kind == stk_pkg::KIND_EOF && rsp_token_length == 16'd0)
      else $error("end-of-source token malformed");

endmodule

bind source_tokenizer stk_checker u_stk_checker (.*);

// File: dv/testbench.sv
module testbench;
   import stk_pkg::*;

   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_DQ  = 8'h22;
   localparam logic [7:0] CH_SQ  = 8'h27;
   localparam logic [7:0] CH_BSL = 8'h5C;
   // Directed rows plus random sources; the overlong name follows.
   localparam int RANDOM_BYTES = 140;
   localparam int HOLD_OFF_CYCLES = 400;

   typedef struct {
      logic [7:0] src_byte;
      logic       eos;
      bit         typed;
      logic [5:0] kind;
      logic [2:0] err;
   } byte_item_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_source_byte = 8'd0;
   logic        req_end_of_source = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [5:0]  rsp_token_kind;
   logic [31:0] rsp_start_line;
   logic [15:0] rsp_start_column;
   logic [31:0] rsp_start_offset;
   logic [15:0] rsp_token_length;
   logic [2:0]  rsp_error_code;
   logic        rsp_last_token;

   source_tokenizer u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_source_byte(req_source_byte), .req_end_of_source(req_end_of_source),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_token_kind(rsp_token_kind), .rsp_start_line(rsp_start_line),
      .rsp_start_column(rsp_start_column), .rsp_start_offset(rsp_start_offset),
      .rsp_token_length(rsp_token_length), .rsp_error_code(rsp_error_code),
      .rsp_last_token(rsp_last_token)
   );

   always #5 clock = ~clock;

   // Directed bytes; kind and error are typed in where the first token is obvious.
   byte_item_t directed_rows [25] = '{
      '{8'h00, 1'b0, 1'b1, KIND_EOF, ERR_BYTE},
      '{"z",   1'b1, 1'b0, KIND_EOF, ERR_NONE},
      '{"_",   1'b0, 1'b0, KIND_EOF, ERR_NONE},
      '{">",   1'b0, 1'b0, KIND_EOF, ERR_NONE},
      '{">",   1'b0, 1'b0, KIND_EOF, ERR_NONE},
      '{"@",   1'b0, 1'b1, KIND_RET_OK, ERR_NONE},
      '{"&",   1'b0, 1'b0, KIND_EOF, ERR_NONE},
      '{"*",   1'b0, 1'b0, KIND_EOF, ERR_NONE},
      '{"*",   1'b0, 1'b1, KIND_BIN, ERR_NONE},
      '{"-",   1'b0, 1'b0, KIND_EOF, ERR_NONE},
      '{"#",   1'b0, 1'b0, KIND_EOF, ERR_NONE},
      '{"q",   1'b0, 1'b0, KIND_EOF, ERR_NONE},
      '{CH_LF, 1'b0, 1'b0, KIND_EOF, ERR_NONE},
      '{"1",   1'b0, 1'b0, KIND_EOF, ERR_NONE},
      '{".",   1'b0, 1'b0, KIND_EOF, ERR_NONE},
      '{"2",   1'b0, 1'b0, KIND_EOF, ERR_NONE},
      '{".",   1'b0, 1'b1, KIND_EOF, ERR_POINT},
      '{"x",   1'b1, 1'b0, KIND_EOF, ERR_NONE},
      '{CH_DQ, 1'b0, 1'b0, KIND_EOF, ERR_NONE},
      '{CH_BSL, 1'b0, 1'b0, KIND_EOF, ERR_NONE},
      '{CH_DQ, 1'b0, 1'b0, KIND_EOF, ERR_NONE},
      '{8'hFF, 1'b1, 1'b1, KIND_EOF, ERR_UNTERM},
      '{" ",   1'b1, 1'b1, KIND_EOF, ERR_NONE},
      '{8'hC8, 1'b0, 1'b0, KIND_EOF, ERR_NONE},
      '{"a",   1'b1, 1'b0, KIND_EOF, ERR_NONE}
   };

   byte_item_t source_items[$];
   result_type token_q[$];
   int         mismatches = 0;
   int         tokens_checked = 0;
   int         sources_sent = 0;

   // Lexer state mirrored by the predictor.
   logic [2:0]  lx_mode;
   logic [7:0]  lx_ahead [4];
   int          lx_ahead_n;
   logic [31:0] lx_line;
   logic [15:0] lx_col;
   logic [31:0] lx_off;
   logic [31:0] tk_line;
   logic [15:0] tk_col;
   logic [31:0] tk_off;
   logic [31:0] tk_chars;
   bit          tk_point;
   bit          tk_escape;
   logic [2:0]  tk_keyword;
   bit          tk_dotted;
   logic [7:0]  tk_quote;
   logic [5:0]  prev_kind;
   bit          lx_at_end;
   int          step_tokens;
   string       keyword_text [6] = '{"", "let", "true", "false", "nil", "as"};

   function automatic void lexer_clear();
      lx_mode = MODE_IDLE;
      lx_ahead_n = 0;
      lx_line = 1;
      lx_col = 1;
      lx_off = 0;
      tk_line = 0;
      tk_col = 0;
      tk_off = 0;
      tk_chars = 0;
      tk_point = 0;
      tk_escape = 0;
      tk_keyword = KW_NONE;
      tk_dotted = 0;
      tk_quote = 0;
      prev_kind = KIND_NONE;
   endfunction

   function automatic void push_token(logic [5:0] kind, logic [31:0] ln, logic [15:0] col,
                                      logic [31:0] off, logic [31:0] len, logic [2:0] err,
                                      logic last);
      result_type r;
      if (step_tokens >= MAX_RESULTS) return;
      r.token_kind = kind;
      r.start_line = ln;
      r.start_column = col;
      r.start_offset = off;
      r.token_length = (len > 32'd65535) ? 16'hFFFF : len[15:0];
      r.error_code = err;
      r.last_token = last;
      token_q.push_back(r);
      step_tokens++;
   endfunction

   function automatic void token_done(logic [5:0] kind, logic [31:0] len);
      push_token(kind, tk_line, tk_col, tk_off, len, ERR_NONE, 1'b0);
      prev_kind = kind;
   endfunction

   function automatic void halt_on(logic [2:0] code, logic [31:0] ln, logic [15:0] col,
                                   logic [31:0] off, logic [31:0] len);
      push_token(KIND_EOF, ln, col, off, len, code, 1'b1);
      lx_mode = MODE_HALTED;
      lx_ahead_n = 0;
   endfunction

   function automatic void consume(int k);
      int j;
      if (k > lx_ahead_n) k = lx_ahead_n;
      for (j = 0; j + k < lx_ahead_n; j++) lx_ahead[j] = lx_ahead[j + k];
      lx_ahead_n -= k;
   endfunction

   function automatic void advance(int k);
      consume(k);
      lx_col = lx_col + 16'(k);
      lx_off = lx_off + 32'(k);
   endfunction

   function automatic void advance_line();
      consume(1);
      lx_line++;
      lx_col = 1;
      lx_off++;
   endfunction

   // -1: source has ended, -2: byte not yet known.
   function automatic int ahead(int k);
      if (k < lx_ahead_n) return lx_ahead[k];
      return lx_at_end ? -1 : -2;
   endfunction

   function automatic bit is_digit(int c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_letter(int c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c >= 128;
   endfunction

   function automatic void mark_token();
      tk_line = lx_line;
      tk_col = lx_col;
      tk_off = lx_off;
   endfunction

   function automatic void punctuator(logic [5:0] kind, int len);
      mark_token();
      token_done(kind, len);
      advance(len);
   endfunction

   // A lone operator is unary at the start of a source or after an operator-like token.
   function automatic void lone_operator();
      bit unary;
      unary = prev_kind == KIND_NONE || prev_kind == KIND_BIN || prev_kind == KIND_LPAREN ||
              prev_kind == KIND_COMMA || prev_kind == KIND_EQUALS;
      punctuator(unary ? KIND_UNARY : KIND_BIN, 1);
   endfunction

   function automatic void close_name();
      logic [5:0] kind;
      kind = KIND_IDENT;
      if (tk_keyword != KW_NONE && tk_chars == keyword_text[tk_keyword].len()) begin
         case (tk_keyword)
            KW_LET:   kind = KIND_LET;
            KW_TRUE,
            KW_FALSE: kind = KIND_BOOL;
            KW_NIL:   kind = KIND_NIL;
            default:  kind = KIND_AS;
         endcase
      end else if (tk_dotted) begin
         kind = KIND_IMPORT_NAME;
      end
      token_done(kind, tk_chars);
      lx_mode = MODE_IDLE;
   endfunction

   // Decides the token at the head of the lookahead; 0 means more bytes are needed.
   function automatic bit idle_decide();
      int b0;
      int b1;
      int b2;
      int b3;
      b0 = ahead(0);
      if (b0 == " " || b0 == CH_TAB || b0 == CH_CR) begin
         advance(1);
         return 1;
      end
      if (b0 == CH_LF) begin
         advance_line();
         return 1;
      end
      case (b0)
         "_": begin
            b1 = ahead(1);
            if (b1 == -2) return 0;
            if (b1 == ">") begin
               b2 = ahead(2);
               if (b2 == -2) return 0;
               if (b2 == ">") begin
                  b3 = ahead(3);
                  if (b3 == -2) return 0;
                  if (b3 == "@") punctuator(KIND_RET_OK, 4);
                  else if (b3 == "!") punctuator(KIND_RET_ERR, 4);
                  else punctuator(KIND_RET, 3);
                  return 1;
               end
            end else if (b1 == "_") begin
               b2 = ahead(2);
               if (b2 == -2) return 0;
               if (b2 == ">") begin
                  punctuator(KIND_CONTINUE, 3);
                  return 1;
               end
            end
         end
         "~": begin
            b1 = ahead(1);
            if (b1 == -2) return 0;
            if (b1 == "!") begin
               b2 = ahead(2);
               if (b2 == -2) return 0;
               if (b2 == "!") begin
                  punctuator(KIND_BREAK, 3);
                  return 1;
               end
            end else if (b1 == ">") begin
               punctuator(KIND_IMPORT_OP, 2);
               return 1;
            end
         end
         "!": begin
            b1 = ahead(1);
            if (b1 == -2) return 0;
            if (b1 == "?") punctuator(KIND_UNWRAP, 2);
            else if (b1 == "=") punctuator(KIND_BIN, 2);
            else lone_operator();
            return 1;
         end
         "?": begin
            b1 = ahead(1);
            if (b1 == -2) return 0;
            if (b1 == "?") punctuator(KIND_MATCH, 2);
            else punctuator(KIND_QUESTION, 1);
            return 1;
         end
         "=": begin
            b1 = ahead(1);
            if (b1 == -2) return 0;
            if (b1 == ">") punctuator(KIND_FAT_ARROW, 2);
            else if (b1 == "=") punctuator(KIND_BIN, 2);
            else punctuator(KIND_EQUALS, 1);
            return 1;
         end
         "|": begin
            b1 = ahead(1);
            if (b1 == -2) return 0;
            if (b1 == "{") punctuator(KIND_OPEN_ARENA, 2);
            else if (b1 == ">") punctuator(KIND_OPEN_TABLE, 2);
            else if (b1 == "|") punctuator(KIND_BIN, 2);
            else punctuator(KIND_BIN, 1);
            return 1;
         end
         "}": begin
            b1 = ahead(1);
            if (b1 == -2) return 0;
            if (b1 == "|") punctuator(KIND_CLOSE_ARENA, 2);
            else punctuator(KIND_RBRACE, 1);
            return 1;
         end
         "<": begin
            b1 = ahead(1);
            if (b1 == -2) return 0;
            if (b1 == "|") punctuator(KIND_CLOSE_TABLE, 2);
            else if (b1 == "=" || b1 == "<") punctuator(KIND_BIN, 2);
            else lone_operator();
            return 1;
         end
         "-": begin
            b1 = ahead(1);
            if (b1 == -2) return 0;
            if (b1 == "#") begin
               lx_mode = MODE_COMMENT;
               advance(1);
            end else if (b1 == ">") begin
               punctuator(KIND_ARROW, 2);
            end else begin
               lone_operator();
            end
            return 1;
         end
         ">": begin
            b1 = ahead(1);
            if (b1 == -2) return 0;
            if (b1 == "=" || b1 == ">") punctuator(KIND_BIN, 2);
            else lone_operator();
            return 1;
         end
         "*": begin
            b1 = ahead(1);
            if (b1 == -2) return 0;
            if (b1 == "*") punctuator(KIND_BIN, 2);
            else lone_operator();
            return 1;
         end
         "&": begin
            b1 = ahead(1);
            if (b1 == -2) return 0;
            if (b1 == "&" || b1 == "+" || b1 == "-" || b1 == "/" || b1 == "%" ||
                b1 == "e" || b1 == "|" || b1 == "~") begin
               punctuator(KIND_BIN, 2);
            end else if (b1 == "*") begin
               b2 = ahead(2);
               if (b2 == -2) return 0;
               punctuator(KIND_BIN, (b2 == "*") ? 3 : 2);
            end else if (b1 == "<" || b1 == ">") begin
               b2 = ahead(2);
               if (b2 == -2) return 0;
               punctuator(KIND_BIN, (b2 == b1) ? 3 : 1);
            end else begin
               punctuator(KIND_BIN, 1);
            end
            return 1;
         end
         "+", "/", "%", "^": begin
            lone_operator();
            return 1;
         end
         "(": begin punctuator(KIND_LPAREN, 1); return 1; end
         ")": begin punctuator(KIND_RPAREN, 1); return 1; end
         "{": begin punctuator(KIND_LBRACE, 1); return 1; end
         "[": begin punctuator(KIND_LBRACKET, 1); return 1; end
         "]": begin punctuator(KIND_RBRACKET, 1); return 1; end
         ";": begin punctuator(KIND_SEMI, 1); return 1; end
         ",": begin punctuator(KIND_COMMA, 1); return 1; end
         ".": begin punctuator(KIND_DOT, 1); return 1; end
         ":": begin punctuator(KIND_COLON, 1); return 1; end
         "#": begin punctuator(KIND_HASH, 1); return 1; end
         "@": begin punctuator(KIND_AT, 1); return 1; end
         "$": begin punctuator(KIND_DOLLAR, 1); return 1; end
         CH_DQ, CH_SQ: begin
            mark_token();
            tk_quote = b0;
            tk_escape = 0;
            tk_chars = 0;
            lx_mode = MODE_STRING;
            advance(1);
            return 1;
         end
         default: ;
      endcase
      if (is_digit(b0)) begin
         mark_token();
         tk_chars = 1;
         tk_point = 0;
         lx_mode = MODE_NUMBER;
         advance(1);
         return 1;
      end
      if (is_letter(b0) || b0 == "_") begin
         mark_token();
         tk_chars = 1;
         tk_dotted = 0;
         case (b0)
            "l":     tk_keyword = KW_LET;
            "t":     tk_keyword = KW_TRUE;
            "f":     tk_keyword = KW_FALSE;
            "n":     tk_keyword = KW_NIL;
            "a":     tk_keyword = KW_AS;
            default: tk_keyword = KW_NONE;
         endcase
         lx_mode = MODE_NAME;
         advance(1);
         return 1;
      end
      halt_on(ERR_BYTE, lx_line, lx_col, lx_off, 1);
      return 1;
   endfunction

   function automatic void number_byte(int c);
      if (is_digit(c) || c == ".") begin
         if (c == "." && tk_point) begin
            halt_on(ERR_POINT, tk_line, tk_col, tk_off, tk_chars);
         end else if (tk_chars >= MAX_NUMBER_CHARS) begin
            halt_on(ERR_LONG, tk_line, tk_col, tk_off, tk_chars);
         end else begin
            if (c == ".") tk_point = 1;
            tk_chars++;
            advance(1);
         end
      end else begin
         token_done(KIND_NUMBER, tk_chars);
         lx_mode = MODE_IDLE;
      end
   endfunction

   function automatic void name_byte(int c);
      string w;
      if (!(is_letter(c) || c == "_" || is_digit(c) || c == ".")) begin
         close_name();
         return;
      end
      if (tk_chars >= MAX_NAME_CHARS) begin
         halt_on(ERR_LONG, tk_line, tk_col, tk_off, tk_chars);
         return;
      end
      if (c == ".") tk_dotted = 1;
      // The keyword guess survives only while the text follows the keyword exactly.
      if (tk_keyword != KW_NONE) begin
         w = keyword_text[tk_keyword];
         if (!(tk_chars < w.len() && w[tk_chars] == c)) tk_keyword = KW_NONE;
      end
      tk_chars++;
      advance(1);
   endfunction

   function automatic void string_byte(int c);
      if (c == tk_quote && !tk_escape) begin
         push_token(KIND_STRING, lx_line, tk_col, tk_off, tk_chars, ERR_NONE, 1'b0);
         prev_kind = KIND_STRING;
         lx_mode = MODE_IDLE;
         advance(1);
         return;
      end
      tk_escape = (c == CH_BSL) && !tk_escape;
      if (tk_chars < 65535) tk_chars++;
      if (c == CH_LF) advance_line();
      else advance(1);
   endfunction

   // Lexes one accepted byte and queues the tokens it completes.
   function automatic int lex_byte(logic [7:0] b, logic eos);
      int c;
      step_tokens = 0;
      lx_at_end = eos;
      if (lx_mode == MODE_HALTED) begin
         if (eos) lexer_clear();
         return 0;
      end
      if (lx_ahead_n < 4) begin
         lx_ahead[lx_ahead_n] = b;
         lx_ahead_n++;
      end
      while (lx_ahead_n > 0 && lx_mode != MODE_HALTED) begin
         c = lx_ahead[0];
         if (lx_mode == MODE_IDLE) begin
            if (!idle_decide()) break;
         end else if (lx_mode == MODE_NUMBER) begin
            number_byte(c);
         end else if (lx_mode == MODE_NAME) begin
            name_byte(c);
         end else if (lx_mode == MODE_STRING) begin
            string_byte(c);
         end else if (c == CH_LF) begin
            lx_mode = MODE_IDLE;
         end else begin
            advance(1);
         end
      end
      if (eos) begin
         if (lx_mode == MODE_NUMBER) token_done(KIND_NUMBER, tk_chars);
         else if (lx_mode == MODE_NAME) close_name();
         else if (lx_mode == MODE_STRING)
            halt_on(ERR_UNTERM, tk_line, tk_col, tk_off, tk_chars);
         if (lx_mode != MODE_HALTED)
            push_token(KIND_EOF, lx_line, lx_col, lx_off, 0, ERR_NONE, 1'b1);
         lexer_clear();
      end
      return step_tokens;
   endfunction

   function automatic void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", msg);
   endfunction

   function automatic void add_byte(logic [7:0] b, logic eos);
      byte_item_t it;
      it.src_byte = b;
      it.eos = eos;
      it.typed = 0;
      it.kind = KIND_EOF;
      it.err = ERR_NONE;
      source_items.push_back(it);
      if (eos) sources_sent++;
   endfunction

   function automatic void add_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
   endfunction

   // Random sources: mostly well-formed token sequences, with noise and broken tails.
   function automatic void build_random_sources();
      string pieces [] = '{"_>>@", "_>>!", "_>>", "~!!", "__>", "!?", "??", "=>", "~>",
         "|{", "}|", "|>", "<|", "->", "&&", "&+", "&-", "&/", "&%", "&e", "&|", "&~",
         "&*", "&**", "&<<", "&<", "&>>", "&>", "&x", "!=", "<=", "<<", ">=", ">>", "**",
         "+", "-", "*", "/", "%", "^", "!", "<", ">", "=", "|", "==", "||", "(", ")",
         "{", "}", "[", "]", ";", ",", ".", ":", "#", "@", "$", "?", "~", "_", "__",
         "let", "true", "false", "nil", "as", "lets", "tru", "a", "fals", "foo.bar",
         "_a1", "x9", "3.14", "42", "7.", "1.2.3", "\"ab\\\"c\"", "'q\\\\'", "\"\"",
         "-# note\n", "-#", " ", " ", "\n", "\t", "  "};
      int total;
      int n;
      int k;
      int i;
      total = 0;
      while (total < RANDOM_BYTES) begin
         n = $urandom_range(2, 14);
         for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 19))
               0: add_byte(8'($urandom_range(0, 255)), 1'b0);
               1: begin
                  add_byte(CH_DQ, 1'b0);
                  for (i = $urandom_range(0, 4); i > 0; i--)
                     add_byte(8'($urandom_range(0, 255)), 1'b0);
                  add_byte(CH_DQ, 1'b0);
               end
               default: add_text(pieces[$urandom_range(0, pieces.size() - 1)]);
            endcase
         end
         // Some sources end inside a string, number or name.
         case ($urandom_range(0, 5))
            0: add_text("'ope");
            1: add_text("12");
            2: add_text("nil");
            default: ;
         endcase
         add_byte($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(0, 255)), 1'b1);
         total = source_items.size();
      end
      // One overlong name.
      for (i = 0; i < 260; i++) add_byte("a", 1'b0);
      add_byte(" ", 1'b1);
      add_text("x=-y");
      add_byte(";", 1'b1);
   endfunction

   // Reset, then the sender works in bursts with random gaps.
   initial begin
      int sent;
      int gap;
      int burst;
      lexer_clear();
      foreach (directed_rows[i]) begin
         source_items.push_back(directed_rows[i]);
         if (directed_rows[i].eos) sources_sent++;
      end
      build_random_sources();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      sent = 0;
      gap = 0;
      burst = $urandom_range(1, 20);
      while (sent < source_items.size()) begin
         @(posedge clock);
         if (req_valid && !req_stall) begin
            sent++;
            burst--;
            if (burst == 0) begin
               burst = $urandom_range(1, 24);
               gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
            end
         end
         if (req_valid && !req_stall || !req_valid) begin
            if (sent >= source_items.size() || gap > 0) begin
               req_valid <= 1'b0;
               if (gap > 0) gap--;
            end else begin
               req_valid <= 1'b1;
               req_source_byte <= source_items[sent].src_byte;
               req_end_of_source <= source_items[sent].eos;
            end
         end
      end
      while (token_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Ran %0d bytes in %0d sources; %0d tokens compared, %0d mismatches.",
               source_items.size(), sources_sent, tokens_checked, mismatches);
      if (mismatches == 0 && token_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Receiver: one long hold-off to fill the block, then its own stall pattern.
   initial begin
      int hold;
      int i;
      rsp_stall <= 1'b0;
      @(negedge reset);
      repeat (40) @(posedge clock);
      hold = 0;
      while (hold < HOLD_OFF_CYCLES) begin
         @(posedge clock);
         rsp_stall <= 1'b1;
         hold++;
      end
      forever begin
         case ($urandom_range(0, 3))
            0: for (i = 0; i < 40; i++) begin
               @(posedge clock);
               rsp_stall <= 1'b0;
            end
            1: for (i = $urandom_range(1, 12); i > 0; i--) begin
               @(posedge clock);
               rsp_stall <= 1'b1;
            end
            default: for (i = 0; i < 30; i++) begin
               @(posedge clock);
               rsp_stall <= ($urandom_range(0, 2) == 0);
            end
         endcase
      end
   end

   // Predict on every accepted byte, check every accepted token.
   int accepted_bytes = 0;
   always @(posedge clock) begin
      result_type want;
      int n;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (token_q.size() == 0) begin
            report($sformatf("unexpected token kind %0d", rsp_token_kind));
         end else begin
            want = token_q.pop_front();
            tokens_checked++;
            if (rsp_token_kind !== want.token_kind)
               report($sformatf("token_kind exp %0d got %0d", want.token_kind, rsp_token_kind));
            if (rsp_start_line !== want.start_line)
               report($sformatf("start_line exp %0d got %0d", want.start_line, rsp_start_line));
            if (rsp_start_column !== want.start_column)
               report($sformatf("start_column exp %0d got %0d", want.start_column,
                                rsp_start_column));
            if (rsp_start_offset !== want.start_offset)
               report($sformatf("start_offset exp %0d got %0d", want.start_offset,
                                rsp_start_offset));
            if (rsp_token_length !== want.token_length)
               report($sformatf("token_length exp %0d got %0d", want.token_length,
                                rsp_token_length));
            if (rsp_error_code !== want.error_code)
               report($sformatf("error_code exp %0d got %0d", want.error_code, rsp_error_code));
            if (rsp_last_token !== want.last_token)
               report($sformatf("last_token exp %0d got %0d", want.last_token, rsp_last_token));
         end
      end
      if (!reset && req_valid && !req_stall) begin
         n = lex_byte(req_source_byte, req_end_of_source);
         // Directed rows with a typed-in first token.
         if (source_items[accepted_bytes].typed) begin
            if (n == 0) begin
               report($sformatf("byte %0d gave no token", accepted_bytes));
            end else begin
               want = token_q[token_q.size() - n];
               if (want.token_kind != source_items[accepted_bytes].kind ||
                   want.error_code != source_items[accepted_bytes].err)
                  report($sformatf("byte %0d exp kind %0d err %0d got kind %0d err %0d",
                                   accepted_bytes, source_items[accepted_bytes].kind,
                                   source_items[accepted_bytes].err, want.token_kind,
                                   want.error_code));
            end
         end
         accepted_bytes++;
      end
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// File: files.f
sv/stk_pkg.sv
sv/stk_core.sv
sv/stk_fifo.sv
sv/source_tokenizer.sv
sv/stk_checker.sv
dv/testbench.sv
